// ===== sv/dfs_topological_sort_defines.svh =====
// Assertion macros for the topological sort block
`ifndef DFS_TOPOLOGICAL_SORT_DEFINES_SVH
`define DFS_TOPOLOGICAL_SORT_DEFINES_SVH
// check an implication every clock, quiet in reset
`define DTS_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// check an implication on the following clock
`define DTS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== sv/dts_pkg.sv =====
`timescale 1ns / 1ps
package dts_pkg;
  localparam int Nodes     = 32;
  localparam int MaxEdges  = 256;
  localparam int NodeW     = $clog2(Nodes);
  localparam int EdgeW     = $clog2(MaxEdges);
  localparam int ECntW     = $clog2(MaxEdges + 1);
  localparam int NCntW     = $clog2(Nodes + 1);
  localparam int CfgW      = 6;
  localparam int AddrW     = 1;

  localparam logic [AddrW-1:0] RegNodeCount = 1'b0;

  typedef enum logic [1:0] {
    MK_NONE = 2'd0,
    MK_TEMP = 2'd1,
    MK_PERM = 2'd2
  } mark_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROOT,
    ST_FETCH,
    ST_WAIT,
    ST_CHECK,
    ST_FINISH,
    ST_EMIT_RD,
    ST_EMIT_WAIT,
    ST_EMIT,
    ST_CYCLE
  } state_e;
endpackage

// ===== sv/dts_ram.sv =====
`timescale 1ns / 1ps
module dts_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== sv/dfs_topological_sort.sv =====
`timescale 1ns / 1ps
// Depth-first topological sort. Edge transfers (mode 0) are taken one per
// cycle while idle and appended to a 256-entry edge RAM; a dropped edge (store
// full or an endpoint at or above the node count) sets a sticky error. A sort
// transfer (mode 1) walks the graph with an explicit 32-deep stack, scanning
// the edge RAM from each frame's saved position through one read port. Each
// scanned edge passes through fetch, RAM read and check steps; a push is done
// in the check step; a frame finds its edge list exhausted in a fetch step and
// is popped in a finish step; each root id is examined in a root step. Emission
// is set up in the emit-read and emit-wait states and then gives one result per
// cycle while the receiver does not stall. Nodes leave in reverse finish order
// (last on the final one); a back edge ends the walk at once with a single
// cycle result. Input stall is high for the whole sort and emission.
// The node_count register sits at byte address 0; 0 acts as 1, above 32 as 32.
module dfs_topological_sort (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [dts_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      valid_i,
  output logic                      stall_o,
  input  logic                      mode_i,
  input  logic [4:0]                src_i,
  input  logic [4:0]                dst_i,
  output logic                      valid_o,
  input  logic                      stall_i,
  output logic [4:0]                node_o,
  output logic                      cycle_o,
  output logic                      error_o,
  output logic                      last_o
);
  import dts_pkg::*;

  state_e state_q, state_d;
  logic [CfgW-1:0]  ncfg_q;
  logic [NCntW-1:0] n_eff;
  logic [ECntW-1:0] etot_q;
  logic             drop_q;
  logic [1:0]       mark_q [Nodes];
  logic [NodeW-1:0] stk_node_q [Nodes];
  logic [EdgeW:0]   stk_pos_q  [Nodes];
  logic [NCntW-1:0] top_q;
  logic [NodeW-1:0] fin_q [Nodes];
  logic [NCntW-1:0] ftot_q, emit_q;
  logic [NCntW-1:0] root_q;
  logic [EdgeW:0]   pos_q;

  logic             in_acc;
  logic             ram_we;
  logic [EdgeW-1:0] ram_raddr;
  logic [9:0]       ram_rdata;
  logic [NodeW-1:0] cur_v, e_from, e_to;
  logic [NodeW-1:0] top_idx;

  // configuration
  assign pready = 1'b1;
  assign prdata = {{(32-CfgW){1'b0}}, ncfg_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ncfg_q <= CfgW'(32);
    end else if (psel && penable && pwrite && paddr == RegNodeCount) begin
      ncfg_q <= pwdata[CfgW-1:0];
    end
  end

  always_comb begin
    if (ncfg_q == '0) n_eff = NCntW'(1);
    else if (CfgW'(ncfg_q) > CfgW'(Nodes)) n_eff = NCntW'(Nodes);
    else n_eff = NCntW'(ncfg_q);
  end

  assign stall_o = (state_q != ST_IDLE);
  assign in_acc  = valid_i && !stall_o;

  assign ram_we = in_acc && !mode_i && (etot_q < ECntW'(MaxEdges))
                  && (NCntW'(src_i) < n_eff) && (NCntW'(dst_i) < n_eff);
  assign ram_raddr = pos_q[EdgeW-1:0];

  dts_ram #(.Width(10), .Depth(MaxEdges)) u_edges (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (etot_q[EdgeW-1:0]),
    .wdata_i ({src_i, dst_i}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign e_from  = ram_rdata[9:5];
  assign e_to    = ram_rdata[4:0];
  assign top_idx = NodeW'(top_q - NCntW'(1));
  assign cur_v   = stk_node_q[top_idx];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc && mode_i) state_d = ST_ROOT;
      ST_ROOT: begin
        if (root_q >= n_eff) state_d = (ftot_q == '0) ? ST_IDLE : ST_EMIT_RD;
        else if (mark_q[root_q[NodeW-1:0]] == MK_NONE) state_d = ST_FETCH;
      end
      ST_FETCH: begin
        if (ECntW'(pos_q) >= etot_q) state_d = ST_FINISH;
        else state_d = ST_WAIT;
      end
      ST_WAIT: state_d = ST_CHECK;
      ST_CHECK: begin
        if (e_from == cur_v && NCntW'(e_to) < n_eff) begin
          if (mark_q[e_to] == MK_TEMP) state_d = ST_CYCLE;
          else state_d = ST_FETCH;
        end else begin
          state_d = ST_FETCH;
        end
      end
      ST_FINISH: state_d = (top_q == NCntW'(1)) ? ST_ROOT : ST_FETCH;
      ST_EMIT_RD: state_d = ST_EMIT_WAIT;
      ST_EMIT_WAIT: state_d = ST_EMIT;
      ST_EMIT: if (!stall_i) state_d = (emit_q == NCntW'(1)) ? ST_IDLE : ST_EMIT;
      ST_CYCLE: if (!stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  // datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      etot_q <= '0;
      drop_q <= 1'b0;
      top_q  <= '0;
      ftot_q <= '0;
      emit_q <= '0;
      root_q <= '0;
      pos_q  <= '0;
      for (int i = 0; i < Nodes; i++) mark_q[i] <= MK_NONE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_acc && !mode_i) begin
            if (ram_we) etot_q <= etot_q + ECntW'(1);
            else drop_q <= 1'b1;
          end
          if (in_acc && mode_i) begin
            for (int i = 0; i < Nodes; i++) mark_q[i] <= MK_NONE;
            top_q  <= '0;
            ftot_q <= '0;
            root_q <= '0;
          end
        end
        ST_ROOT: begin
          if (root_q >= n_eff) begin
            if (ftot_q == '0) begin
              etot_q <= '0;
              drop_q <= 1'b0;
            end
            emit_q <= ftot_q;
          end else if (mark_q[root_q[NodeW-1:0]] == MK_NONE) begin
            stk_node_q[0] <= root_q[NodeW-1:0];
            top_q <= NCntW'(1);
            pos_q <= '0;
            mark_q[root_q[NodeW-1:0]] <= MK_TEMP;
          end else begin
            root_q <= root_q + NCntW'(1);
          end
        end
        ST_CHECK: begin
          pos_q <= pos_q + (EdgeW+1)'(1);
          if (e_from == cur_v && NCntW'(e_to) < n_eff) begin
            if (mark_q[e_to] == MK_NONE) begin
              // push: save resume position, open new frame
              stk_pos_q[top_idx] <= pos_q + (EdgeW+1)'(1);
              stk_node_q[NodeW'(top_q)] <= e_to;
              mark_q[e_to] <= MK_TEMP;
              top_q <= top_q + NCntW'(1);
              pos_q <= '0;
            end
          end
        end
        ST_FINISH: begin
          mark_q[cur_v] <= MK_PERM;
          fin_q[NodeW'(ftot_q)] <= cur_v;
          ftot_q <= ftot_q + NCntW'(1);
          top_q <= top_q - NCntW'(1);
          if (top_q != NCntW'(1)) pos_q <= stk_pos_q[NodeW'(top_q - NCntW'(2))];
          else root_q <= root_q + NCntW'(1);
        end
        ST_EMIT: begin
          if (!stall_i) begin
            emit_q <= emit_q - NCntW'(1);
            if (emit_q == NCntW'(1)) begin
              etot_q <= '0;
              drop_q <= 1'b0;
            end
          end
        end
        ST_CYCLE: begin
          if (!stall_i) begin
            etot_q <= '0;
            drop_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // outputs
  always_comb begin
    valid_o = 1'b0;
    node_o  = '0;
    cycle_o = 1'b0;
    error_o = drop_q;
    last_o  = 1'b0;
    case (state_q)
      ST_EMIT: begin
        valid_o = 1'b1;
        node_o  = fin_q[NodeW'(emit_q - NCntW'(1))];
        last_o  = (emit_q == NCntW'(1));
      end
      ST_CYCLE: begin
        valid_o = 1'b1;
        cycle_o = 1'b1;
        last_o  = 1'b1;
      end
      default: ;
    endcase
  end
endmodule

// ===== sv/dts_checker.sv =====
`timescale 1ns / 1ps
`include "dfs_topological_sort_defines.svh"
module dts_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic valid_i,
  input logic stall_o,
  input logic mode_i,
  input logic valid_o,
  input logic stall_i,
  input logic cycle_o,
  input logic last_o,
  input logic [4:0] node_o
);
  `DTS_ASSERT_IMPL(a_cycle_last, clk_i, rst_ni, valid_o && cycle_o, last_o && node_o == 5'd0,
    "cycle result must be last with node zero")
  `DTS_ASSERT_NEXT(a_sort_busy, clk_i, rst_ni, valid_i && !stall_o && mode_i, stall_o,
    "sort transfer must busy the input")
  `DTS_ASSERT_IMPL(a_out_busy, clk_i, rst_ni, valid_o, stall_o,
    "result shown while input ready")
  `DTS_ASSERT_NEXT(a_hold, clk_i, rst_ni, valid_o && stall_i, valid_o && $stable(node_o),
    "stalled result changed")
endmodule

bind dfs_topological_sort dts_checker u_dts_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(valid_i), .stall_o(stall_o),
  .mode_i(mode_i), .valid_o(valid_o), .stall_i(stall_i), .cycle_o(cycle_o),
  .last_o(last_o), .node_o(node_o)
);
